// ===== src/ncf_pkg.sv =====
// Types, constants and helpers shared by the NTP reply clock filter.
`timescale 1ns / 1ps
package ncf_pkg;

    localparam int FILTER_DEPTH_DEF = 8;

    localparam logic [7:0] STRATUM_MAX = 8'd15;
    localparam logic [3:0] TRUST_BAD   = 4'd6;
    localparam logic [3:0] TRUST_MAX   = 4'd10;
    localparam logic [3:0] TRUST_RESET = 4'd2;
    localparam logic [1:0] LEAP_ALARM  = 2'd3;

    typedef enum logic [2:0] {
        V_ACCEPT  = 3'd0,
        V_BADLEN  = 3'd1,
        V_COOKIE  = 3'd2,
        V_UNSYNC  = 3'd3,
        V_NEGDLY  = 3'd4,
        V_TIMEOUT = 3'd5
    } t_verdict;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SUM,
        ST_CHECK,
        ST_SCAN,
        ST_PRUNE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [63:0] sent_time;
        logic [63:0] server_rx_time;
        logic [63:0] server_tx_time;
        logic [63:0] arrival_time;
        logic [63:0] echoed_origin;
        logic [63:0] query_cookie;
        logic [1:0]  leap_bits;
        logic [7:0]  stratum;
        logic        length_ok;
    } t_in_item;

    typedef struct packed {
        t_verdict           verdict;
        logic signed [63:0] sample_offset;
        logic signed [63:0] sample_delay;
        logic [3:0]         trust_level;
        logic               update_valid;
        logic signed [63:0] best_offset;
        logic signed [63:0] best_delay;
        logic [3:0]         best_stratum;
        logic [1:0]         best_leap;
    } t_out_item;

    // One ring entry as it sits in the filter memory.
    typedef struct packed {
        logic [63:0] offset;
        logic [63:0] delay;
        logic [3:0]  stratum;
        logic [1:0]  leap;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Clamp a 66-bit two's complement value to the signed 64-bit range.
    function automatic logic [63:0] sat66(logic [65:0] x);
        logic [63:0] r;
        if (x[65:63] == 3'b000 || x[65:63] == 3'b111) begin
            r = x[63:0];
        end else if (x[65]) begin
            r = 64'h8000_0000_0000_0000;
        end else begin
            r = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return r;
    endfunction

endpackage

// ===== src/ncf_stream_if.sv =====
// Valid/ready channel interfaces for the filter's input and result items.
`timescale 1ns / 1ps
interface ncf_in_if;
    import ncf_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ncf_out_if;
    import ncf_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/ntp_reply_clock_filter.sv =====
// NTP reply clock filter: sample checks, offset/delay, ring memory and min-delay pick.
// From accept, timeouts and failed packet checks go straight to the emit state; accepted
// replies pass the diff, sum and check states, then emit on a negative delay or a ring left
// short; a full ring adds the min-delay scan, one entry read a cycle, and then the prune.
// One item in flight: input ready returns together with result valid, even while that
// result still waits at the output. Reset clears state, valid bits, write slot
// and output valid and sets trust to 2; the ring memory is not cleared.
`timescale 1ns / 1ps
module ntp_reply_clock_filter #(
    parameter int FILTER_DEPTH = ncf_pkg::FILTER_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ncf_in_if.sink    i_in,
    ncf_out_if.source o_out
);
    import ncf_pkg::*;

    localparam int AW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CW = $clog2(FILTER_DEPTH + 1);
    localparam logic [AW:0]   DEPTH_A   = (AW+1)'(FILTER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(FILTER_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(FILTER_DEPTH - 1);

    t_state r_state, n_state;

    logic [FILTER_DEPTH-1:0] r_valid, n_valid;
    logic [AW-1:0]           r_ws, n_ws;
    logic [3:0]              r_trust, n_trust;
    logic                    r_out_valid, n_out_valid;
    t_out_item               r_out, n_out;
    logic                    r_rd_pend, n_rd_pend;
    logic [CW-1:0]           r_scan, n_scan;
    logic [AW-1:0]           r_rd_idx, n_rd_idx;
    logic                    r_have, n_have;
    logic [AW-1:0]           r_best_idx, n_best_idx;
    t_entry                  r_best, n_best;
    logic                    r_upd, n_upd;
    t_verdict                r_verdict, n_verdict;
    logic [63:0]             r_t1, n_t1, r_t2, n_t2, r_t3, n_t3, r_t4, n_t4;
    logic [1:0]              r_leap, n_leap;
    logic [3:0]              r_strat, n_strat;
    logic signed [64:0]      r_d21, n_d21, r_d34, n_d34, r_d41, n_d41, r_d32, n_d32;
    logic signed [65:0]      r_sum, n_sum, r_dly, n_dly;
    logic [63:0]             r_off_s, n_off_s, r_dly_s, n_dly_s;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_raddr;
    t_entry                  ram_wdata, ram_rdata;
    logic [FILTER_DEPTH-1:0] slot_bit, filled;
    logic [AW-1:0]           ws_next, best_age;

    function automatic logic [AW-1:0] age_of(logic [AW-1:0] slot, logic [AW-1:0] idx);
        logic [AW:0] s;
        s = {1'b0, slot} + DEPTH_A - {1'b0, idx};
        if (s >= DEPTH_A) begin
            s = s - DEPTH_A;
        end
        return s[AW-1:0];
    endfunction

    ncf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FILTER_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ws),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign slot_bit = FILTER_DEPTH'(1) << r_ws;
    assign filled   = r_valid | slot_bit;
    assign ws_next  = (r_ws == LAST_SLOT) ? '0 : r_ws + 1'b1;
    assign best_age = age_of(r_ws, r_best_idx);

    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_ws        <= '0;
            r_trust     <= TRUST_RESET;
            r_out_valid <= 1'b0;
            r_rd_pend   <= 1'b0;
        end else begin
            r_valid     <= n_valid;
            r_ws        <= n_ws;
            r_trust     <= n_trust;
            r_out_valid <= n_out_valid;
            r_rd_pend   <= n_rd_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_scan     <= n_scan;
        r_rd_idx   <= n_rd_idx;
        r_have     <= n_have;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_upd      <= n_upd;
        r_verdict  <= n_verdict;
        r_t1       <= n_t1;
        r_t2       <= n_t2;
        r_t3       <= n_t3;
        r_t4       <= n_t4;
        r_leap     <= n_leap;
        r_strat    <= n_strat;
        r_d21      <= n_d21;
        r_d34      <= n_d34;
        r_d41      <= n_d41;
        r_d32      <= n_d32;
        r_sum      <= n_sum;
        r_dly      <= n_dly;
        r_off_s    <= n_off_s;
        r_dly_s    <= n_dly_s;
    end

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_ws        = r_ws;
        n_trust     = r_trust;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_rd_pend   = r_rd_pend;
        n_scan      = r_scan;
        n_rd_idx    = r_rd_idx;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_upd       = r_upd;
        n_verdict   = r_verdict;
        n_t1        = r_t1;
        n_t2        = r_t2;
        n_t3        = r_t3;
        n_t4        = r_t4;
        n_leap      = r_leap;
        n_strat     = r_strat;
        n_d21       = r_d21;
        n_d34       = r_d34;
        n_d41       = r_d41;
        n_d32       = r_d32;
        n_sum       = r_sum;
        n_dly       = r_dly;
        n_off_s     = r_off_s;
        n_dly_s     = r_dly_s;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_raddr   = r_scan[AW-1:0];
        ram_wdata   = '{offset: r_off_s, delay: r_dly_s, stratum: r_strat, leap: r_leap};

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_t1    = i_in.data.sent_time;
                    n_t2    = i_in.data.server_rx_time;
                    n_t3    = i_in.data.server_tx_time;
                    n_t4    = i_in.data.arrival_time;
                    n_leap  = i_in.data.leap_bits;
                    n_strat = i_in.data.stratum[3:0];
                    n_off_s = '0;
                    n_dly_s = '0;
                    n_upd   = 1'b0;
                    n_state = ST_EMIT;
                    priority if (i_in.data.kind) begin
                        n_verdict = V_TIMEOUT;
                        if (r_trust >= TRUST_BAD) begin
                            n_trust = r_trust >> 1;
                        end
                    end else if (!i_in.data.length_ok) begin
                        n_verdict = V_BADLEN;
                    end else if (i_in.data.echoed_origin != i_in.data.query_cookie) begin
                        n_verdict = V_COOKIE;
                    end else if (i_in.data.leap_bits == LEAP_ALARM ||
                                 i_in.data.stratum == 8'd0 ||
                                 i_in.data.stratum > STRATUM_MAX) begin
                        n_verdict = V_UNSYNC;
                    end else begin
                        n_verdict = V_ACCEPT;
                        n_state   = ST_DIFF;
                    end
                end
            end
            ST_DIFF: begin
                n_d21   = $signed({1'b0, r_t2}) - $signed({1'b0, r_t1});
                n_d34   = $signed({1'b0, r_t3}) - $signed({1'b0, r_t4});
                n_d41   = $signed({1'b0, r_t4}) - $signed({1'b0, r_t1});
                n_d32   = $signed({1'b0, r_t3}) - $signed({1'b0, r_t2});
                n_state = ST_SUM;
            end
            ST_SUM: begin
                n_sum   = {r_d21[64], r_d21} + {r_d34[64], r_d34};
                n_dly   = {r_d41[64], r_d41} - {r_d32[64], r_d32};
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                // arithmetic shift gives the floor of the half
                n_off_s = sat66({r_sum[65], r_sum[65:1]});
                n_dly_s = sat66(r_dly);
                if (r_dly[65]) begin
                    n_verdict = V_NEGDLY;
                    n_state   = ST_EMIT;
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = '{offset: n_off_s, delay: n_dly_s,
                                  stratum: r_strat, leap: r_leap};
                    n_valid   = filled;
                    if (r_trust < TRUST_MAX) begin
                        n_trust = r_trust + 4'd1;
                    end
                    if (&filled) begin
                        n_scan    = '0;
                        n_have    = 1'b0;
                        n_rd_pend = 1'b0;
                        n_state   = ST_SCAN;
                    end else begin
                        n_ws    = ws_next;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan < DEPTH_C) begin
                    ram_re = 1'b1;
                    n_scan = r_scan + 1'b1;
                end
                n_rd_pend = (r_scan < DEPTH_C);
                n_rd_idx  = r_scan[AW-1:0];
                // strict less-than keeps the lowest index on a tie
                if (r_rd_pend && (!r_have ||
                        $signed(ram_rdata.delay) < $signed(r_best.delay))) begin
                    n_best     = ram_rdata;
                    n_best_idx = r_rd_idx;
                    n_have     = 1'b1;
                end
                if (r_scan == DEPTH_C) begin
                    n_state = ST_PRUNE;
                end
            end
            ST_PRUNE: begin
                // drop the pick and everything older than it
                for (int i = 0; i < FILTER_DEPTH; i++) begin
                    if (age_of(r_ws, AW'(i)) >= best_age) begin
                        n_valid[i] = 1'b0;
                    end
                end
                n_upd   = 1'b1;
                n_ws    = ws_next;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid         = 1'b1;
                    n_out.verdict       = r_verdict;
                    n_out.sample_offset = $signed(r_off_s);
                    n_out.sample_delay  = $signed(r_dly_s);
                    n_out.trust_level   = r_trust;
                    n_out.update_valid  = r_upd;
                    n_out.best_offset   = r_upd ? $signed(r_best.offset) : '0;
                    n_out.best_delay    = r_upd ? $signed(r_best.delay) : '0;
                    n_out.best_stratum  = r_upd ? r_best.stratum : 4'd0;
                    n_out.best_leap     = r_upd ? r_best.leap : 2'd0;
                    n_state             = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // a full ring is always pruned before the next item
    a_ring_not_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !(&r_valid))
        else $error("ring full while idle");

    a_scan_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (&r_valid))
        else $error("scan started on a partly filled ring");

    a_trust_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trust <= TRUST_MAX)
        else $error("trust above its ceiling");

    a_update_on_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.update_valid) |-> (r_out.verdict == V_ACCEPT))
        else $error("filter update on a rejected item");

endmodule

// ===== src/ncf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ncf_ram #(
    parameter int WIDTH = ncf_pkg::ENTRY_W,
    parameter int DEPTH = ncf_pkg::FILTER_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== tb/ncf_filter_checker.sv =====
// Checker for the NTP reply clock filter: watches both channels, predicts each result, compares.
`timescale 1ns / 1ps
module ncf_filter_checker #(
    parameter int FILTER_DEPTH = ncf_pkg::FILTER_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ncf_in_if    i_in_ch,
    ncf_out_if   i_res_ch,
    output int   o_fail_count,
    output int   o_pending
);
    import ncf_pkg::*;

    // Shadow copy of the filter state
    logic [63:0]        ring_off  [FILTER_DEPTH];
    logic signed [63:0] ring_dly  [FILTER_DEPTH];
    logic [3:0]         ring_str  [FILTER_DEPTH];
    logic [1:0]         ring_lp   [FILTER_DEPTH];
    bit                 ring_live [FILTER_DEPTH];
    int                 slot;
    logic [3:0]         trust;

    t_out_item expected_results[$];
    int        n_results;

    // Exact difference of two unsigned 32.32 stamps, with headroom for sums.
    function automatic logic signed [67:0] span(logic [63:0] a, logic [63:0] b);
        return $signed({4'b0, a}) - $signed({4'b0, b});
    endfunction

    function automatic logic [63:0] clamp_s64(logic signed [67:0] v);
        if (v[67:63] == 5'b00000 || v[67:63] == 5'b11111) begin
            return v[63:0];
        end
        return v[67] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    endfunction

    task automatic report(string msg);
        $display("ERROR %0t: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            report($sformatf("%s of result %0d: expected %h, got %h",
                             name, n_results, want, got));
        end
    endtask

    task automatic step_filter(input t_in_item it, output t_out_item r);
        logic signed [67:0] off_x;
        logic signed [67:0] dly_x;
        int live;
        int best;
        int best_age;
        bit found;
        r = '0;
        if (it.kind) begin
            if (trust >= TRUST_BAD) begin
                trust = trust >> 1;
            end
            r.verdict = V_TIMEOUT;
        end else if (!it.length_ok) begin
            r.verdict = V_BADLEN;
        end else if (it.echoed_origin != it.query_cookie) begin
            r.verdict = V_COOKIE;
        end else if (it.leap_bits == LEAP_ALARM || it.stratum == 8'd0
                     || it.stratum > STRATUM_MAX) begin
            r.verdict = V_UNSYNC;
        end else begin
            off_x = span(it.server_rx_time, it.sent_time)
                  + span(it.server_tx_time, it.arrival_time);
            off_x = off_x >>> 1;
            dly_x = span(it.arrival_time, it.sent_time)
                  - span(it.server_tx_time, it.server_rx_time);
            r.sample_offset = clamp_s64(off_x);
            r.sample_delay  = clamp_s64(dly_x);
            // sign test on the exact delay, not the clamped one
            if (dly_x[67]) begin
                r.verdict = V_NEGDLY;
            end else begin
                ring_off[slot]  = r.sample_offset;
                ring_dly[slot]  = r.sample_delay;
                ring_str[slot]  = it.stratum[3:0];
                ring_lp[slot]   = it.leap_bits;
                ring_live[slot] = 1'b1;
                if (trust < TRUST_MAX) begin
                    trust = trust + 4'd1;
                end
                live  = 0;
                best  = 0;
                found = 1'b0;
                for (int i = 0; i < FILTER_DEPTH; i++) begin
                    if (ring_live[i]) begin
                        live++;
                        if (!found || ring_dly[i] < ring_dly[best]) begin
                            best  = i;
                            found = 1'b1;
                        end
                    end
                end
                if (live == FILTER_DEPTH) begin
                    r.update_valid = 1'b1;
                    r.best_offset  = ring_off[best];
                    r.best_delay   = ring_dly[best];
                    r.best_stratum = ring_str[best];
                    r.best_leap    = ring_lp[best];
                    // drop the pick and everything older, counting back from the newest
                    best_age = (slot + FILTER_DEPTH - best) % FILTER_DEPTH;
                    for (int i = 0; i < FILTER_DEPTH; i++) begin
                        if ((slot + FILTER_DEPTH - i) % FILTER_DEPTH >= best_age) begin
                            ring_live[i] = 1'b0;
                        end
                    end
                end
                slot = (slot + 1) % FILTER_DEPTH;
                r.verdict = V_ACCEPT;
            end
        end
        r.trust_level = trust;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            for (int i = 0; i < FILTER_DEPTH; i++) begin
                ring_live[i] = 1'b0;
            end
            slot  = 0;
            trust = TRUST_RESET;
            expected_results.delete();
        end else begin
            if (i_res_ch.valid && i_res_ch.ready) begin
                got = i_res_ch.data;
                if (expected_results.size() == 0) begin
                    report($sformatf("result %0d arrived with no prediction waiting",
                                     n_results));
                end else begin
                    want = expected_results.pop_front();
                    compare_field("verdict", 64'(want.verdict), 64'(got.verdict));
                    compare_field("sample_offset", want.sample_offset, got.sample_offset);
                    compare_field("sample_delay",  want.sample_delay,  got.sample_delay);
                    compare_field("trust_level", 64'(want.trust_level),
                                  64'(got.trust_level));
                    compare_field("update_valid", 64'(want.update_valid),
                                  64'(got.update_valid));
                    compare_field("best_offset",   want.best_offset,   got.best_offset);
                    compare_field("best_delay",    want.best_delay,    got.best_delay);
                    compare_field("best_stratum", 64'(want.best_stratum),
                                  64'(got.best_stratum));
                    compare_field("best_leap", 64'(want.best_leap), 64'(got.best_leap));
                end
                n_results++;
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                step_filter(i_in_ch.data, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/ntp_reply_clock_filter_tb.sv =====
// Testbench top for the NTP reply clock filter: clock, reset, stimulus, back-pressure, verdict.
`timescale 1ns / 1ps
module ntp_reply_clock_filter_tb;
    import ncf_pkg::*;

    localparam int          RAND_ITEMS  = 1200;
    localparam int          TAIL_ITEMS  = 150;
    localparam int          LONG_HOLD   = 300;
    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [63:0] TS_MAX      = '1;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   cycles = 0;
    bit   hold_req;
    bit   hold_done;
    bit   calm_tail;

    ncf_in_if  in_ch ();
    ncf_out_if out_ch ();

    ntp_reply_clock_filter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ncf_filter_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_res_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Well-formed reply around the given stamps
    function automatic t_in_item good_reply(logic [63:0] t1, logic [63:0] t2,
                                            logic [63:0] t3, logic [63:0] t4);
        t_in_item it;
        it.kind           = 1'b0;
        it.sent_time      = t1;
        it.server_rx_time = t2;
        it.server_tx_time = t3;
        it.arrival_time   = t4;
        it.query_cookie   = rand64();
        it.echoed_origin  = it.query_cookie;
        it.leap_bits      = 2'($urandom_range(0, 2));
        it.stratum        = 8'($urandom_range(1, 15));
        it.length_ok      = 1'b1;
        return it;
    endfunction

    function automatic t_in_item random_item();
        t_in_item    it;
        logic [63:0] t1;
        logic [63:0] skew;
        logic [63:0] proc;
        logic [63:0] rtt;
        int          pick;
        pick = $urandom_range(0, 99);
        it.kind           = 1'b0;
        it.sent_time      = rand64();
        it.server_rx_time = rand64();
        it.server_tx_time = rand64();
        it.arrival_time   = rand64();
        it.echoed_origin  = rand64();
        it.query_cookie   = $urandom_range(0, 1) ? it.echoed_origin : rand64();
        it.leap_bits      = 2'($urandom);
        it.stratum        = 8'($urandom);
        it.length_ok      = ($urandom_range(0, 7) != 0);
        if (pick < 10) begin
            it.kind = 1'b1;
        end else if (pick >= 25) begin
            if (pick < 92) begin
                // plausible exchange: server skew, processing time, small round trip
                t1   = rand64();
                skew = {{32{1'($urandom)}}, $urandom};
                proc = {48'd0, 16'($urandom)};
                rtt  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(0, 7))
                                                   : {24'd0, 8'($urandom), $urandom};
                it = good_reply(t1, t1 + skew, t1 + skew + proc, t1 + proc + rtt);
            end else begin
                it = good_reply(rand64(), rand64(), rand64(), rand64());
            end
        end
        return it;
    endfunction

    // Call at a falling edge; returns at the falling edge after the transaction, valid still high.
    task automatic offer(input t_in_item item);
        in_ch.data  = item;
        in_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Result side: random stall bursts, one long hold-off, none in the tail.
    initial begin
        int n;
        bit gappy;
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        gappy        = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                out_ch.ready = 1'b0;
                hold_done    = 1'b1;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
            end else if (gappy && !calm_tail && $urandom_range(0, 3) == 0) begin
                out_ch.ready = 1'b0;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
            if ($urandom_range(0, 63) == 0) begin
                gappy = !gappy;
            end
        end
    end

    initial begin
        t_in_item it;
        bit       gappy;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        i_rst_n     = 1'b0;
        hold_req    = 1'b0;
        calm_tail   = 1'b0;
        gappy       = 1'b1;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // timeout at the reset trust level leaves trust alone
        it      = '0;
        it.kind = 1'b1;
        offer(it);

        // rejections, in check order
        it = good_reply(64'd100, 64'd150, 64'd160, 64'd220);
        it.length_ok = 1'b0;
        offer(it);
        it = good_reply(64'd100, 64'd150, 64'd160, 64'd220);
        it.echoed_origin = ~it.query_cookie;
        offer(it);
        it = good_reply(64'd100, 64'd150, 64'd160, 64'd220);
        it.leap_bits = LEAP_ALARM;
        offer(it);
        it = good_reply(64'd100, 64'd150, 64'd160, 64'd220);
        it.stratum = 8'd0;
        offer(it);
        it.stratum = STRATUM_MAX + 8'd1;
        offer(it);
        it.stratum = 8'hFF;
        offer(it);

        // negative delay: by one, and clamped at the low end
        offer(good_reply(64'd0, 64'd0, 64'd1, 64'd0));
        offer(good_reply(TS_MAX, 64'd0, TS_MAX, 64'd0));

        // eight accepts fill the ring: clamped offsets, clamped delay, floor of -1/2
        it = good_reply(64'd0, TS_MAX, TS_MAX, 64'd0);
        it.stratum   = 8'd1;
        it.leap_bits = 2'd0;
        offer(it);
        it = good_reply(TS_MAX, 64'd0, 64'd0, TS_MAX);
        it.stratum   = STRATUM_MAX;
        it.leap_bits = 2'd2;
        offer(it);
        it = good_reply(64'd0, TS_MAX, 64'd0, TS_MAX);
        it.leap_bits = 2'd1;
        offer(it);
        offer(good_reply(64'd0, 64'd0, 64'd0, 64'd1));
        // zero-delay ties: the lowest index wins
        repeat (4) begin
            it.sent_time = rand64();
            offer(good_reply(it.sent_time, it.sent_time + 64'd5,
                             it.sent_time + 64'd9, it.sent_time + 64'd4));
        end

        // newest entry is the pick, so the whole ring is dropped
        it           = '1;
        it.kind      = 1'b0;
        it.leap_bits = 2'd2;
        it.stratum   = STRATUM_MAX;
        offer(it);

        // trust at the top is halved once, then left alone
        it      = '0;
        it.kind = 1'b1;
        offer(it);
        offer(it);

        hold_req = 1'b1;
        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS - TAIL_ITEMS) begin
                calm_tail = 1'b1;
            end
            if (k == RAND_ITEMS / 2) begin
                // drain completely before going on
                in_ch.valid = 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
            offer(random_item());
            if (gappy && !calm_tail && $urandom_range(0, 3) == 0) begin
                in_ch.valid = 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge i_clk);
            end
            if ($urandom_range(0, 49) == 0) begin
                gappy = !gappy;
            end
        end
        in_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
